[hw/rtl/pcfd_pkg.sv]
// ----------------------------------------------------------------------------
// pcfd_pkg: shared definitions for the pulse charge and CFD timing block
// Holds default parameters, output ranges, register codes, controller
// states and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package pcfd_pkg;

	// Default build parameters.
	localparam int MAX_SAMPLES_DEF      = 128;
	localparam int PEDESTAL_SAMPLES_DEF = 30;
	localparam int CFD_DELAY_DEF        = 2;
	localparam int SAMPLE_BITS_DEF      = 12;

	// Fixed field widths.
	localparam int PED_W    = 16;
	localparam int THR_W    = 12;
	localparam int CHARGE_W = 25;
	localparam int TIME_W   = 19;
	localparam int CHAN_W   = 4;
	localparam int CFG_W    = 16;

	// Saturation limits and the threshold reset value.
	localparam int CHARGE_MIN = -16777216;
	localparam int CHARGE_MAX = 16777215;
	localparam int TIME_MIN   = -4096;
	localparam int TIME_MAX   = 262143;
	localparam int PED_MAX    = 65535;
	localparam int THR_RESET  = 4095;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_THRESHOLD = 2'd0,
		REG_PED_CH0   = 2'd1,
		REG_PED_CH1   = 2'd2
	} reg_index_t;

	// Controller states.
	typedef enum logic [3:0] {
		ST_LOAD,
		ST_CHECK,
		ST_PDIV,
		ST_CHARGE,
		ST_RDA,
		ST_EVA,
		ST_RDB,
		ST_EVB,
		ST_TDIV,
		ST_RESULT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic ped_stored;
		logic ped_div;
		logic ped_take;
		logic charge;
		logic rd_b;
		logic ev_a;
		logic dec;
		logic t_div;
		logic t_take;
		logic nohit;
		logic out_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic hit;
		logic use_stored;
		logic search_ok;
		logic a_neg;
		logic idx_one;
		logic a2_gt;
		logic div_done;
		logic out_free;
	} status_t;

endpackage

[hw/rtl/pcfd_ctrl.sv]
// ----------------------------------------------------------------------------
// pcfd_ctrl: sequencing controller
// Steps one window through loading, pedestal, charge, backward CFD search,
// interpolation divide and result hand-off.
// ----------------------------------------------------------------------------
module pcfd_ctrl import pcfd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	input  logic    s_tlast,
	output logic    s_tready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					if (s_tlast) state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (!status.hit) begin
					cmd.nohit = 1'b1;
					state_d   = ST_RESULT;
				end else if (status.use_stored) begin
					cmd.ped_stored = 1'b1;
					state_d        = ST_CHARGE;
				end else begin
					cmd.ped_div = 1'b1;
					state_d     = ST_PDIV;
				end
			end
			ST_PDIV: begin
				if (status.div_done) begin
					cmd.ped_take = 1'b1;
					state_d      = ST_CHARGE;
				end
			end
			ST_CHARGE: begin
				cmd.charge = 1'b1;
				state_d    = status.search_ok ? ST_RDA : ST_RESULT;
			end
			ST_RDA: begin
				state_d = ST_EVA;
			end
			ST_EVA: begin
				cmd.ev_a = 1'b1;
				if (status.a_neg) begin
					state_d = ST_RDB;
				end else if (status.idx_one) begin
					state_d = ST_RESULT;
				end else begin
					cmd.dec = 1'b1;
					state_d = ST_RDA;
				end
			end
			ST_RDB: begin
				cmd.rd_b = 1'b1;
				state_d  = ST_EVB;
			end
			ST_EVB: begin
				if (status.a2_gt) begin
					cmd.t_div = 1'b1;
					state_d   = ST_TDIV;
				end else begin
					state_d = ST_RESULT;
				end
			end
			ST_TDIV: begin
				if (status.div_done) begin
					cmd.t_take = 1'b1;
					state_d    = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_LOAD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

endmodule

[hw/rtl/pcfd_div.sv]
// ----------------------------------------------------------------------------
// pcfd_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle; shared by the pedestal
// mean and the CFD interpolation.
// ----------------------------------------------------------------------------
module pcfd_div import pcfd_pkg::*; #(
	parameter int DW = 36
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [DW-1:0] quo,
	output logic          done
);

	localparam int CNT_W = $clog2(DW + 1);

	logic [DW-1:0]    num_q, den_q, rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q, done_q;
	logic [DW:0]      rem_sh, rem_sub;
	logic             ge;

	// One shift-and-subtract step.
	assign rem_sh  = {rem_q, num_q[DW-1]};
	assign ge      = rem_sh >= {1'b0, den_q};
	assign rem_sub = rem_sh - {1'b0, den_q};

	// Control of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(DW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Remainder and quotient registers.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
			num_q <= {num_q[DW-2:0], ge};
		end
	end

	assign quo  = num_q;
	assign done = done_q;

endmodule

[hw/rtl/pcfd_dp.sv]
// ----------------------------------------------------------------------------
// pcfd_dp: datapath
// Sample store, running window statistics, pedestals, charge, CFD values,
// shared divider and the output register.
// ----------------------------------------------------------------------------
module pcfd_dp import pcfd_pkg::*; #(
	parameter int MAX_SAMPLES      = MAX_SAMPLES_DEF,
	parameter int PEDESTAL_SAMPLES = PEDESTAL_SAMPLES_DEF,
	parameter int CFD_DELAY        = CFD_DELAY_DEF,
	parameter int SAMPLE_BITS      = SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic [CHAN_W-1:0]      channel_id,
	input  logic                   cfg_we,
	input  logic [1:0]             cfg_index,
	input  logic [CFG_W-1:0]       cfg_data,
	input  logic                   m_tready,
	input  cmd_t                   cmd,
	output status_t                status,
	output logic                   out_valid,
	output logic [CHARGE_W-1:0]    out_charge,
	output logic [TIME_W-1:0]      out_time,
	output logic                   out_hit,
	output logic                   out_cfd_valid
);

	localparam int SB   = SAMPLE_BITS;
	localparam int CW   = $clog2(MAX_SAMPLES + 1);
	localparam int IW   = $clog2(MAX_SAMPLES);
	localparam int WSW  = SB + CW;
	localparam int ESW  = SB + $clog2(PEDESTAL_SAMPLES + 1);
	localparam int NEW  = $clog2(PEDESTAL_SAMPLES + 1);
	localparam int XW   = ((SB + 4 > PED_W) ? SB + 4 : PED_W) + 1;
	localparam int AW   = XW + 2;
	localparam int NW   = AW + 11;
	localparam int PNW  = ESW + 5;
	localparam int DW   = (NW > PNW) ? NW : PNW;
	localparam int TW0  = ((DW > IW + 11) ? DW : IW + 11) + 2;
	localparam int TW   = (TW0 < 21) ? 21 : TW0;
	localparam int CHW0 = ((WSW + 4 > CW + PED_W) ? WSW + 4 : CW + PED_W) + 2;
	localparam int CHW  = (CHW0 < 26) ? 26 : CHW0;
	localparam int PRW  = CW + PED_W;

	localparam logic signed [CHW-1:0] CH_LO = CHW'(CHARGE_MIN);
	localparam logic signed [CHW-1:0] CH_HI = CHW'(CHARGE_MAX);
	localparam logic signed [TW-1:0]  T_LO  = TW'(TIME_MIN);
	localparam logic signed [TW-1:0]  T_HI  = TW'(TIME_MAX);

	// Configuration and pedestal registers.
	logic [THR_W-1:0] thr_q;
	logic [PED_W-1:0] ped0_q, ped1_q, ped_q;

	// Window statistics.
	logic [CW-1:0]     cnt_q;
	logic              cross_f_q;
	logic [IW-1:0]     cross_idx_q, peak_idx_q;
	logic [SB-1:0]     peak_q;
	logic [WSW-1:0]    wsum_q;
	logic [ESW-1:0]    esum_q;
	logic [CHAN_W-1:0] ch_q;

	// Sample store and search state.
	logic [SB-1:0]        mem [MAX_SAMPLES];
	logic [SB-1:0]        rd0_s1, rd1_s1;
	logic                 d_en_s1;
	logic [IW-1:0]        ra0, ra1, i_q;
	logic signed [AW-1:0] a1_q, a_cur;
	logic signed [XW-1:0] x0, x1;

	// Divider hookup.
	logic [DW-1:0] div_num, div_den, div_quo;
	logic          div_done;

	// Result fields.
	logic                      out_valid_q, hit_q, cv_q;
	logic [CHARGE_W-1:0]       charge_q;
	logic [TIME_W-1:0]         time_q;

	// Derived values.
	logic                 in_store, cross_early;
	logic [CW:0]          st_peak, st_lim, st;
	logic [NEW-1:0]       ne;
	logic [PRW-1:0]       prod;
	logic signed [CHW-1:0] charge_full;
	logic signed [AW:0]   den_t;
	logic [NW-1:0]        num_t;
	logic signed [TW-1:0] t_full;
	logic [PED_W-1:0]     ped_new;

	assign in_store    = 32'(cnt_q) < MAX_SAMPLES;
	assign cross_early = 32'(cross_idx_q) < PEDESTAL_SAMPLES;

	// Configuration writes; a newly computed pedestal also loads the stored pedestal of channel 0 or 1.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= THR_W'(THR_RESET);
			ped0_q <= '0;
			ped1_q <= '0;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_THRESHOLD: thr_q  <= cfg_data[THR_W-1:0];
				REG_PED_CH0:   ped0_q <= cfg_data;
				REG_PED_CH1:   ped1_q <= cfg_data;
				default: ;
			endcase
		end else if (cmd.ped_take) begin
			if (ch_q == CHAN_W'(0)) ped0_q <= ped_new;
			if (ch_q == CHAN_W'(1)) ped1_q <= ped_new;
		end
	end

	// Running statistics over the window.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			cross_f_q   <= 1'b0;
			cross_idx_q <= '0;
			peak_q      <= '0;
			peak_idx_q  <= '0;
			wsum_q      <= '0;
			esum_q      <= '0;
		end else if (cmd.out_load) begin
			cnt_q       <= '0;
			cross_f_q   <= 1'b0;
			cross_idx_q <= '0;
			peak_q      <= '0;
			peak_idx_q  <= '0;
			wsum_q      <= '0;
			esum_q      <= '0;
		end else if (cmd.load && in_store) begin
			if (!cross_f_q && (SB'(sample) > SB'(thr_q))) begin
				cross_f_q   <= 1'b1;
				cross_idx_q <= cnt_q[IW-1:0];
			end
			if (sample > peak_q) begin
				peak_q     <= sample;
				peak_idx_q <= cnt_q[IW-1:0];
			end
			wsum_q <= wsum_q + WSW'(sample);
			if (32'(cnt_q) < PEDESTAL_SAMPLES) esum_q <= esum_q + ESW'(sample);
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// The channel of the last sample of the window is the one used.
	always_ff @(posedge clk) begin
		if (cmd.load) ch_q <= channel_id;
	end

	// Sample store write and two registered read ports.
	assign ra0 = cmd.rd_b ? i_q + 1'b1 : i_q;
	assign ra1 = ra0 - IW'(CFD_DELAY);

	always_ff @(posedge clk) begin
		if (cmd.load && in_store) mem[cnt_q[IW-1:0]] <= sample;
		rd0_s1  <= mem[ra0];
		rd1_s1  <= mem[ra1];
		d_en_s1 <= 32'(ra0) >= CFD_DELAY;
	end

	// CFD value: twice the delayed sample minus the current, pedestal removed.
	assign x0    = $signed(XW'({rd0_s1, 4'b0000})) - $signed(XW'(ped_q));
	assign x1    = d_en_s1 ? ($signed(XW'({rd1_s1, 4'b0000})) - $signed(XW'(ped_q))) : '0;
	assign a_cur = (AW'(x1) <<< 1) - AW'(x0);

	// Search start: peak plus delay, clamped to two below the count.
	assign st_peak = (CW + 1)'(peak_idx_q) + (CW + 1)'(CFD_DELAY);
	assign st_lim  = (CW + 1)'(cnt_q) - (CW + 1)'(2);
	assign st      = (st_peak > st_lim) ? st_lim : st_peak;

	// Search index.
	always_ff @(posedge clk) begin
		if (cmd.charge) i_q <= st[IW-1:0];
		else if (cmd.dec) i_q <= i_q - 1'b1;
		if (cmd.ev_a) a1_q <= a_cur;
	end

	// Pedestal selection.
	always_ff @(posedge clk) begin
		if (cmd.ped_stored) ped_q <= (ch_q == CHAN_W'(0)) ? ped0_q : ped1_q;
		else if (cmd.ped_take) ped_q <= ped_new;
	end

	assign ped_new = (div_quo > DW'(PED_MAX)) ? PED_W'(PED_MAX) : div_quo[PED_W-1:0];

	// Divider operands: pedestal mean or interpolation fraction.
	assign ne    = (32'(cnt_q) < PEDESTAL_SAMPLES) ? NEW'(cnt_q) : NEW'(PEDESTAL_SAMPLES);
	assign den_t = (AW + 1)'(a_cur) - (AW + 1)'(a1_q);
	assign num_t = (NW'(-a1_q) << 10) + NW'(den_t >>> 1);

	always_comb begin
		if (cmd.t_div) begin
			div_num = DW'(num_t);
			div_den = DW'(den_t);
		end else begin
			div_num = (DW'(esum_q) << 4) + DW'(ne >> 1);
			div_den = DW'(ne);
		end
	end

	pcfd_div #(.DW(DW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.ped_div | cmd.t_div),
		.num    (div_num),
		.den    (div_den),
		.quo    (div_quo),
		.done   (div_done)
	);

	// Charge: sixteen times the sum less count times pedestal.
	assign prod        = PRW'(cnt_q) * PRW'(ped_q);
	assign charge_full = $signed(CHW'(wsum_q) << 4) - $signed(CHW'(prod));

	// Time: bin offset plus the interpolated fraction.
	assign t_full = $signed(((TW'(i_q) - TW'(CFD_DELAY)) << 10) + TW'(div_quo));

	// Result fields.
	always_ff @(posedge clk) begin
		if (cmd.nohit) begin
			charge_q <= '0;
			time_q   <= '0;
			hit_q    <= 1'b0;
			cv_q     <= 1'b0;
		end else if (cmd.charge) begin
			if (charge_full < CH_LO) charge_q <= CH_LO[CHARGE_W-1:0];
			else if (charge_full > CH_HI) charge_q <= CH_HI[CHARGE_W-1:0];
			else charge_q <= charge_full[CHARGE_W-1:0];
			time_q <= '0;
			hit_q  <= 1'b1;
			cv_q   <= 1'b0;
		end else if (cmd.t_take) begin
			if (t_full < T_LO) time_q <= T_LO[TIME_W-1:0];
			else if (t_full > T_HI) time_q <= T_HI[TIME_W-1:0];
			else time_q <= t_full[TIME_W-1:0];
			cv_q <= 1'b1;
		end
	end

	// Output register: holds a result until it is taken.
	logic [CHARGE_W-1:0] ocharge_q;
	logic [TIME_W-1:0]   otime_q;
	logic                ohit_q, ocv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			ocharge_q <= charge_q;
			otime_q   <= time_q;
			ohit_q    <= hit_q;
			ocv_q     <= cv_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_charge    = ocharge_q;
	assign out_time      = otime_q;
	assign out_hit       = ohit_q;
	assign out_cfd_valid = ocv_q;

	// Status toward the controller.
	always_comb begin
		status            = '0;
		status.hit        = cross_f_q;
		status.use_stored = cross_early && (ch_q == CHAN_W'(0) || ch_q == CHAN_W'(1));
		status.search_ok  = (cross_idx_q != '0) && (32'(cnt_q) > 2);
		status.a_neg      = a_cur[AW-1];
		status.idx_one    = i_q == IW'(1);
		status.a2_gt      = a_cur > a1_q;
		status.div_done   = div_done;
		status.out_free   = !out_valid_q || m_tready;
	end

endmodule

[hw/rtl/pulse_charge_cfd_time_top.sv]
// ----------------------------------------------------------------------------
// pulse_charge_cfd_time_top: pulse charge and constant-fraction timing
// Flow: a window of N samples loads one sample per cycle while s_tvalid is
// high; after the last sample follow the pedestal (a divided mean when
// used), the charge, a backward CFD search over the indices, a check of a
// negative CFD value against the next one and, when a crossing is found,
// the time interpolation divide. Throughput: one window at a time.
// The divider, the search and output back-pressure set the gap.
// Reset: arst_n clears control, threshold to 4095, pedestals to zero.
// ----------------------------------------------------------------------------
module pulse_charge_cfd_time_top import pcfd_pkg::*; #(
	parameter int MAX_SAMPLES      = MAX_SAMPLES_DEF,
	parameter int PEDESTAL_SAMPLES = PEDESTAL_SAMPLES_DEF,
	parameter int CFD_DELAY        = CFD_DELAY_DEF,
	parameter int SAMPLE_BITS      = SAMPLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,  // sample
	input  logic                                s_tlast,  // last_sample
	input  logic [CHAN_W-1:0]                   s_tuser,  // channel_id
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [47:0]                         m_tdata,  // charge, hit_time
	output logic [1:0]                          m_tuser,  // hit_found, cfd_valid
	input  logic                                cfg_we,
	input  logic [1:0]                          cfg_index,
	input  logic [CFG_W-1:0]                    cfg_data
);

	cmd_t                cmd;
	status_t             status;
	logic [CHARGE_W-1:0] out_charge;
	logic [TIME_W-1:0]   out_time;
	logic                out_hit, out_cv;

	// Sequencing controller.
	pcfd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// Datapath.
	pcfd_dp #(
		.MAX_SAMPLES      (MAX_SAMPLES),
		.PEDESTAL_SAMPLES (PEDESTAL_SAMPLES),
		.CFD_DELAY        (CFD_DELAY),
		.SAMPLE_BITS      (SAMPLE_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample        (s_tdata[SAMPLE_BITS-1:0]),
		.channel_id    (s_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.m_tready      (m_tready),
		.cmd           (cmd),
		.status        (status),
		.out_valid     (m_tvalid),
		.out_charge    (out_charge),
		.out_time      (out_time),
		.out_hit       (out_hit),
		.out_cfd_valid (out_cv)
	);

	// Result packing.
	assign m_tdata = {4'b0000, out_time, out_charge};
	assign m_tuser = {out_cv, out_hit};

endmodule

[test/pulse_charge_cfd_time_top_tb.sv]
// ----------------------------------------------------------------------------
// pulse_charge_cfd_time_top_tb: window-level check of pulse charge and CFD time
// Sends digitized pulse windows with random gaps on both sides, predicts the
// charge, pedestal choice and constant-fraction time of each closed window,
// and compares every result field by field in arrival order.
// ----------------------------------------------------------------------------
module pulse_charge_cfd_time_top_tb;
	import pcfd_pkg::*;

	localparam int NSAMP  = 128;
	localparam int NPED   = 30;
	localparam int DLY    = 2;
	localparam int WDOG   = 20000;

	typedef struct {
		logic signed [CHARGE_W-1:0] charge;
		logic signed [TIME_W-1:0]   hit_time;
		logic                       hit_found;
		logic                       cfd_valid;
	} pulse_result_t;

	// Scoreboard: predicts results from accepted samples and checks outputs.
	class pulse_scoreboard;
		int unsigned thr;
		int unsigned ped_ch[2];
		int unsigned wave[NSAMP];
		int unsigned cnt, cross_idx, peak_val, peak_idx;
		bit          crossed;
		longint      wsum, esum;
		pulse_result_t pending[$];
		int errors;

		function void reset_state();
			thr = THR_RESET;
			ped_ch[0] = 0;
			ped_ch[1] = 0;
			errors = 0;
			clear_window();
		endfunction

		function void clear_window();
			cnt = 0; crossed = 0; cross_idx = 0;
			peak_val = 0; peak_idx = 0; wsum = 0; esum = 0;
		endfunction

		function void write_reg(reg_index_t idx, int unsigned v);
			case (idx)
				REG_THRESHOLD: thr = v & 12'hFFF;
				REG_PED_CH0:   ped_ch[0] = v & 16'hFFFF;
				REG_PED_CH1:   ped_ch[1] = v & 16'hFFFF;
				default: ;
			endcase
		endfunction

		function longint cfd_twice(int unsigned i, longint p);
			longint x, d;
			x = longint'(wave[i]) * 16 - p;
			d = 0;
			if (i >= DLY) d = longint'(wave[i-DLY]) * 16 - p;
			return 2 * d - x;
		endfunction

		// Take one accepted sample; close the window on last.
		function void note_sample(int unsigned s, bit last, int unsigned ch);
			pulse_result_t r;
			longint p, q, a1, a2, den, t;
			int unsigned ne, start;
			int i;
			if (cnt < NSAMP) begin
				wave[cnt] = s;
				if (!crossed && s > thr) begin
					crossed = 1;
					cross_idx = cnt;
				end
				if (s > peak_val) begin
					peak_val = s;
					peak_idx = cnt;
				end
				wsum += s;
				if (cnt < NPED) esum += s;
				cnt++;
			end
			if (!last) return;
			r = '{default: 0};
			if (crossed && cnt != 0) begin
				if (cross_idx < NPED && ch < 2) begin
					p = ped_ch[ch];
				end else begin
					ne = (cnt < NPED) ? cnt : NPED;
					q = (16 * esum + ne / 2) / ne;
					if (q > PED_MAX) q = PED_MAX;
					p = q;
					if (ch < 2) ped_ch[ch] = q;
				end
				q = wsum * 16 - longint'(cnt) * p;
				if (q < CHARGE_MIN) q = CHARGE_MIN;
				if (q > CHARGE_MAX) q = CHARGE_MAX;
				r.charge = CHARGE_W'(q);
				r.hit_found = 1;
				if (cross_idx > 0 && cnt >= 2) begin
					start = peak_idx + DLY;
					if (start > cnt - 2) start = cnt - 2;
					for (i = start; i > 0; i--) begin
						a1 = cfd_twice(i, p);
						if (a1 < 0) begin
							a2 = cfd_twice(i + 1, p);
							if (a2 > a1) begin
								den = a2 - a1;
								t = 1024 * (i - DLY) + (1024 * (-a1) + den / 2) / den;
								if (t < TIME_MIN) t = TIME_MIN;
								if (t > TIME_MAX) t = TIME_MAX;
								r.hit_time = TIME_W'(t);
								r.cfd_valid = 1;
							end
							break;
						end
					end
				end
			end
			pending.push_back(r);
			clear_window();
		endfunction

		// Compare one accepted result with the oldest prediction.
		function void check_result(logic [47:0] d, logic [1:0] u);
			pulse_result_t e;
			logic signed [CHARGE_W-1:0] c;
			logic signed [TIME_W-1:0]   t;
			c = d[CHARGE_W-1:0];
			t = d[CHARGE_W+TIME_W-1:CHARGE_W];
			if (pending.size() == 0) begin
				$display("%0t: unexpected result charge=%0d time=%0d", $time, c, t);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (c !== e.charge) begin
				$display("%0t: charge exp %0d got %0d", $time, e.charge, c);
				errors++;
			end
			if (t !== e.hit_time) begin
				$display("%0t: hit_time exp %0d got %0d", $time, e.hit_time, t);
				errors++;
			end
			if (u[0] !== e.hit_found) begin
				$display("%0t: hit_found exp %0b got %0b", $time, e.hit_found, u[0]);
				errors++;
			end
			if (u[1] !== e.cfd_valid) begin
				$display("%0t: cfd_valid exp %0b got %0b", $time, e.cfd_valid, u[1]);
				errors++;
			end
			if (d[47:CHARGE_W+TIME_W] !== '0) begin
				$display("%0t: tdata pad exp 0 got %0h", $time, d[47:CHARGE_W+TIME_W]);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [15:0] s_tdata = 0;
	logic        s_tlast = 0;
	logic [3:0]  s_tuser = 0;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [47:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_we = 0;
	logic [1:0]  cfg_index = 0;
	logic [15:0] cfg_data = 0;

	pulse_scoreboard sb;
	int  idle_cycles;
	bit  stall_long;
	int  sample_buf[$];

	pulse_charge_cfd_time_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tlast(s_tlast), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// Monitor transfers on both sides at the rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_sample(s_tdata[11:0], s_tlast, s_tuser);
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata, m_tuser);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if (idle_cycles >= WDOG) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	// Receiver: random stalls, with one long hold-off on request.
	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_long) begin
				m_tready <= 0;
				repeat (600) @(negedge clk);
				stall_long = 0;
			end
			g = gap_len();
			if (g > 0) begin
				m_tready <= 0;
				repeat (g - 1) @(negedge clk);
			end else begin
				m_tready <= 1;
			end
		end
	end

	task automatic cfg_write(reg_index_t idx, int unsigned v);
		@(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= 16'(v);
		@(negedge clk);
		cfg_we <= 0;
		sb.write_reg(idx, v);
	endtask

	// Wait for all results, then for the longest tail of a closed window.
	task automatic drain();
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (400) @(negedge clk);
	endtask

	task automatic send_sample(int s, bit last, int ch, bit gaps);
		int g;
		if (gaps) begin
			g = gap_len();
			if (g > 0) begin
				s_tvalid <= 0;
				repeat (g) @(negedge clk);
			end
		end
		s_tvalid <= 1;
		s_tdata <= 16'(s);
		s_tlast <= last;
		s_tuser <= 4'(ch);
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// Send the buffered window; all samples carry the same channel.
	task automatic send_window(int ch, bit gaps);
		int i;
		for (i = 0; i < sample_buf.size(); i++)
			send_sample(sample_buf[i], i == sample_buf.size() - 1, ch, gaps);
		s_tvalid <= 0;
	endtask

	// Build a pulse: baseline with noise, a shaped peak at a given position.
	task automatic make_pulse(int n, int base, int pos, int amp);
		int i, v, k;
		sample_buf.delete();
		for (i = 0; i < n; i++) begin
			v = base + $urandom_range(0, 6) - 3;
			k = i - pos;
			if (k >= 0 && k < 8) v += amp * (8 - k) * (k + 1) / 20;
			if (v < 0) v = 0;
			if (v > 4095) v = 4095;
			sample_buf.push_back(v);
		end
	endtask

	task automatic send_flat(int n, int v, int ch);
		int i;
		sample_buf.delete();
		for (i = 0; i < n; i++) sample_buf.push_back(v);
		send_window(ch, 1);
	endtask

	initial begin
		int w, n, kind, ch, i;
		sb = new();
		sb.reset_state();
		idle_cycles = 0;
		stall_long = 0;
		repeat (3) @(negedge clk);
		arst_n = 1;

		// Directed: reset threshold gives no hit; single-sample window.
		send_flat(3, 4095, 0);
		send_flat(1, 0, 5);
		drain();
		cfg_write(REG_THRESHOLD, 0);
		send_flat(1, 4095, 0);
		send_flat(2, 1, 1);
		drain();
		cfg_write(REG_PED_CH0, 16'hFFFF);
		cfg_write(REG_PED_CH1, 0);
		cfg_write(REG_THRESHOLD, 100);
		// Stored pedestal at its maximum drives charge negative.
		make_pulse(6, 10, 2, 4000);
		send_window(0, 0);
		make_pulse(8, 4000, 3, 0);
		sample_buf[0] = 0;
		send_window(1, 0);
		// Late crossing: pedestal from the early mean, channel 15.
		make_pulse(60, 50, 40, 3000);
		send_window(15, 1);
		// Long window past the store size: zeros, then a high plateau, on channel 0.
		make_pulse(140, 4095, 120, 0);
		for (i = 0; i < 40; i++) sample_buf[i] = 0;
		send_window(0, 1);
		drain();

		// Random windows with a few configuration phases.
		for (w = 0; w < 16; w++) begin
			if (w % 6 == 0) begin
				drain();
				cfg_write(REG_THRESHOLD, (w == 12) ? 4095 : $urandom_range(0, 4095) % 600);
				cfg_write(REG_PED_CH0, $urandom_range(0, 65535));
				cfg_write(REG_PED_CH1, (w == 6) ? 65535 : $urandom_range(0, 2000));
			end
			if (w == 3) stall_long = 1;
			kind = $urandom_range(0, 9);
			ch = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 1);
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 135) : $urandom_range(8, 24);
			if (kind < 7) begin
				make_pulse(n, $urandom_range(0, 200), $urandom_range(0, n - 1),
					$urandom_range(0, 4095));
			end else begin
				sample_buf.delete();
				for (i = 0; i < n; i++) sample_buf.push_back($urandom_range(0, 4095));
			end
			send_window(ch, 1);
		end
		drain();
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

[sim.f]
hw/rtl/pcfd_pkg.sv
hw/rtl/pcfd_ctrl.sv
hw/rtl/pcfd_div.sv
hw/rtl/pcfd_dp.sv
hw/rtl/pulse_charge_cfd_time_top.sv
test/pulse_charge_cfd_time_top_tb.sv
